// ===== hw/rtl/ctp_pkg.sv =====
package ctp_pkg;

   // Pool size; any value from 1 to 16
   localparam int TIMER_SLOTS = 16;
   localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int MASK_SLOTS  = 16;
   localparam logic [8:0] SLOT_LIMIT = 9'(TIMER_SLOTS);

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_ALLOC = 2'd1,
      OP_SET   = 2'd2
   } op_type;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   // One captured request, presented to the slot bank for the cycle it is processed
   typedef struct packed {
      logic        fire;
      logic [1:0]  op;
      logic [7:0]  idx;
      logic [31:0] load;
   } cmd_type;

   typedef struct packed {
      logic                   status;
      logic [3:0]             granted;
      logic [MASK_SLOTS-1:0]  expired;
      logic [TIMER_SLOTS-1:0] assigned;
   } bank_out_type;

endpackage

// ===== hw/rtl/ctp_slot_bank.sv =====
module ctp_slot_bank (
   input  logic                  clock,
   input  logic                  reset,
   input  ctp_pkg::cmd_type      cmd,
   output ctp_pkg::bank_out_type result
);
   import ctp_pkg::*;

   logic [TIMER_SLOTS-1:0] assigned_ff, assigned_in;
   logic [31:0]            count_ff [TIMER_SLOTS];
   logic [31:0]            count_in [TIMER_SLOTS];
   logic                   free_found;
   logic [SLOT_W-1:0]      free_idx;
   logic                   set_ok;
   logic                   status;
   logic [3:0]             granted;
   logic [MASK_SLOTS-1:0]  expired;

   // Lowest-numbered free slot; scanning downward lets the lowest index win
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
         if (!assigned_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   assign set_ok = ({1'b0, cmd.idx} < SLOT_LIMIT) && assigned_ff[cmd.idx[SLOT_W-1:0]];

   always_comb begin
      assigned_in = assigned_ff;
      for (int i = 0; i < TIMER_SLOTS; i++) begin
         count_in[i] = count_ff[i];
      end
      status  = STATUS_FAIL;
      granted = 4'd0;
      unique case (cmd.op)
         OP_TICK: begin
            status = STATUS_OK;
            for (int i = 0; i < TIMER_SLOTS; i++) begin
               if (count_ff[i] != 32'd0) begin
                  count_in[i] = count_ff[i] - 32'd1;
               end
            end
         end
         OP_ALLOC: begin
            if (free_found) begin
               status                = STATUS_OK;
               granted               = 4'(free_idx);
               assigned_in[free_idx] = 1'b1;
            end
         end
         OP_SET: begin
            if (set_ok) begin
               status                            = STATUS_OK;
               count_in[cmd.idx[SLOT_W-1:0]] = cmd.load;
            end
         end
         default: begin
            status = STATUS_FAIL;
         end
      endcase
   end

   // Zero mask reflects the state after this beat
   always_comb begin
      expired = '0;
      for (int i = 0; i < MASK_SLOTS; i++) begin
         if (i < TIMER_SLOTS) begin
            expired[i] = (count_in[i % TIMER_SLOTS] == 32'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         assigned_ff <= '0;
         for (int i = 0; i < TIMER_SLOTS; i++) begin
            count_ff[i] <= 32'd0;
         end
      end else if (cmd.fire) begin
         assigned_ff <= assigned_in;
         for (int i = 0; i < TIMER_SLOTS; i++) begin
            count_ff[i] <= count_in[i];
         end
      end
   end

   assign result.status   = status;
   assign result.granted  = granted;
   assign result.expired  = expired;
   assign result.assigned = assigned_ff;

endmodule

// ===== hw/rtl/countdown_timer_pool.sv =====
// Pool of countdown timers with one result beat per request beat. A tick
// request bumps the 32-bit tick count and decrements every nonzero timer; an
// allocate request claims the lowest free slot; a set request loads a value
// into an assigned slot. Each request passes through an input register, is
// processed against the slot bank, and lands in the result register, so a
// new request is taken every cycle; only a stalled result register holds
// the pipe. Slots are released only by reset.
module countdown_timer_pool (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_slot_index,
   input  logic [31:0] req_load_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [3:0]  rsp_granted_index,
   output logic [31:0] rsp_tick_total,
   output logic [15:0] rsp_expired_mask
);
   import ctp_pkg::*;

   // input register stage
   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_op_ff;
   logic [7:0]  s1_idx_ff;
   logic [31:0] s1_load_ff;

   // result register stage
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_status_ff;
   logic [3:0]  rsp_granted_ff;
   logic [31:0] rsp_tick_ff;
   logic [15:0] rsp_mask_ff;

   logic [31:0]  tick_count_ff, tick_count_in;
   logic         advance;
   logic         req_take;
   cmd_type      cmd;
   bank_out_type bank;

   // The captured beat moves on whenever the result slot is empty or draining
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign cmd.fire = advance;
   assign cmd.op   = s1_op_ff;
   assign cmd.idx  = s1_idx_ff;
   assign cmd.load = s1_load_ff;

   ctp_slot_bank u_bank (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .result (bank)
   );

   // tick count wraps mod 2^32
   assign tick_count_in = (s1_op_ff == OP_TICK) ? tick_count_ff + 32'd1 : tick_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         tick_count_ff <= 32'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            tick_count_ff <= tick_count_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff   <= req_operation;
         s1_idx_ff  <= req_slot_index;
         s1_load_ff <= req_load_value;
      end
      if (advance) begin
         rsp_status_ff  <= bank.status;
         rsp_granted_ff <= bank.granted;
         rsp_tick_ff    <= tick_count_in;
         rsp_mask_ff    <= bank.expired;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_index = rsp_granted_ff;
   assign rsp_tick_total    = rsp_tick_ff;
   assign rsp_expired_mask  = rsp_mask_ff;

   // Only a processed tick moves the tick count
   a_tick_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      !(advance && (s1_op_ff == OP_TICK)) |=> $stable(tick_count_ff))
      else $error("tick count moved without a tick");

   // At most one slot is claimed per processed beat
   a_one_claim: assert property (@(posedge clock) disable iff (reset)
      advance |=> ($countones(bank.assigned) == $past($countones(bank.assigned)) ||
                   $countones(bank.assigned) == $past($countones(bank.assigned)) + 1))
      else $error("more than one slot claimed in a beat");

   // Slot ownership never changes while nothing is processed
   a_assigned_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(bank.assigned))
      else $error("slot ownership changed while idle");

   // A held result with a pending beat must back-pressure the request side
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("request taken while pipe is blocked");

endmodule
